// ----- design/atl_pkg.sv -----
// Shared types, constants and the arctangent table for the tilt angle block.
package atl_pkg;

   localparam int FULL_TENTHS = 900;
   localparam int ANGLE_STEPS_MAX = 24;
   localparam int ITER_W = $clog2(ANGLE_STEPS_MAX);
   localparam int SQRT_CYCLES = 16;
   localparam logic [7:0] REPORT_RESET = 8'd25;
   localparam logic [26:0] FULL_ANGLE_Q16 = 27'(FULL_TENTHS * 65536);

   typedef logic signed [15:0] sample_type;
   typedef logic signed [10:0] angle_type;
   typedef logic [ITER_W-1:0] iter_type;
   typedef logic [30:0] square_type;
   typedef logic [31:0] root_type;
   typedef logic signed [35:0] cordic_type;
   typedef logic signed [29:0] zacc_type;
   typedef logic [25:0] atan_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

   function automatic atan_type atan_entry(input iter_type idx);
      atan_type val;
      unique case (idx)
         5'd0: val = 26'd29491200;
         5'd1: val = 26'd17409672;
         5'd2: val = 26'd9198793;
         5'd3: val = 26'd4669451;
         5'd4: val = 26'd2343786;
         5'd5: val = 26'd1173036;
         5'd6: val = 26'd586661;
         5'd7: val = 26'd293348;
         5'd8: val = 26'd146676;
         5'd9: val = 26'd73339;
         5'd10: val = 26'd36669;
         5'd11: val = 26'd18335;
         5'd12: val = 26'd9167;
         5'd13: val = 26'd4584;
         5'd14: val = 26'd2292;
         5'd15: val = 26'd1146;
         5'd16: val = 26'd573;
         5'd17: val = 26'd286;
         5'd18: val = 26'd143;
         5'd19: val = 26'd72;
         5'd20: val = 26'd36;
         5'd21: val = 26'd18;
         5'd22: val = 26'd9;
         5'd23: val = 26'd4;
         default: val = 26'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/atl_channels.sv -----
// Valid/ready channel interfaces for the sample input and the angle result.
interface atl_req_if;
   logic valid;
   logic ready;
   atl_pkg::sample_type accel_x;
   atl_pkg::sample_type accel_y;
   atl_pkg::sample_type accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atl_rsp_if;
   logic valid;
   logic ready;
   atl_pkg::angle_type alpha_tenths;
   atl_pkg::angle_type beta_tenths;
   atl_pkg::angle_type gamma_tenths;

   modport source (output valid, output alpha_tenths, output beta_tenths,
                   output gamma_tenths, input ready);
   modport sink (input valid, input alpha_tenths, input beta_tenths,
                 input gamma_tenths, output ready);
endinterface

// ----- design/atl_isqrt.sv -----
// Iterative square root of a 32-bit value scaled by 2^32, two root bits per cycle.
module atl_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  atl_pkg::root_type       operand,
   output atl_pkg::root_type       root,
   output atl_pkg::sqrt_stat_type  stat
);

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   atl_pkg::root_type root_ff, root_in;
   logic [3:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [34:0] shifted_a, trial_a, shifted_b, trial_b;
   logic [33:0] rem_a, rem_b;
   atl_pkg::root_type root_a, root_b;

   always_comb begin
      shifted_a = {rem_ff[32:0], rad_ff[63:62]};
      trial_a = {1'b0, root_ff, 2'b01};
      if (shifted_a >= trial_a) begin
         rem_a = 34'(shifted_a - trial_a);
         root_a = {root_ff[30:0], 1'b1};
      end else begin
         rem_a = 34'(shifted_a);
         root_a = {root_ff[30:0], 1'b0};
      end
      shifted_b = {rem_a[32:0], rad_ff[61:60]};
      trial_b = {1'b0, root_a, 2'b01};
      if (shifted_b >= trial_b) begin
         rem_b = 34'(shifted_b - trial_b);
         root_b = {root_a[30:0], 1'b1};
      end else begin
         rem_b = 34'(shifted_b);
         root_b = {root_a[30:0], 1'b0};
      end
   end

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in = {operand, 32'd0};
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[59:0], 4'd0};
         rem_in = rem_b;
         root_in = root_b;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(atl_pkg::SQRT_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- design/accel_tilt_angles.sv -----
// Top level of the decimating three-axis accelerometer tilt angle block.
//
//   channel   direction  handshake          contents
//   req_chan  in         valid / ready      accel_x, accel_y, accel_z
//   rsp_chan  out        valid / ready      alpha_tenths, beta_tenths, gamma_tenths
//   csr_*     in         write enable only  report_interval
//
// A sample that does not report, or whose three axes are all zero, leaves the sequencer idle.
// A reporting sample is squared per axis, then passes the square root unit (two root bits
// per cycle) and the shared CORDIC rotator, run once per axis, before the result is emitted.
// The input is ready only while the sequencer is idle; a result held in the output register
// does not block it.
// A second finished result waits in the sequencer until the output register is free.
// Reset is synchronous and restores the report interval to 25 and the sample count to zero.
module accel_tilt_angles #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   atl_req_if.sink          req_chan,
   atl_rsp_if.source        rsp_chan,
   input  logic             csr_write_en,
   input  logic [7:0]       csr_write_data
);

   localparam int STEP_COUNT = (CORDIC_STEPS > atl_pkg::ANGLE_STEPS_MAX) ?
                               atl_pkg::ANGLE_STEPS_MAX : CORDIC_STEPS;
   localparam atl_pkg::iter_type LAST_ITER = atl_pkg::iter_type'(STEP_COUNT - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQUARE = 7'b0000010,
      ST_LAUNCH = 7'b0000100,
      ST_ROOT   = 7'b0001000,
      ST_ROT    = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] interval_ff, interval_in;
   logic [1:0] axis_ff, axis_in;
   atl_pkg::sample_type samp_ff [3];
   atl_pkg::sample_type samp_in [3];
   atl_pkg::square_type sq_ff [3];
   atl_pkg::square_type sq_in [3];
   atl_pkg::angle_type ang_ff [3];
   atl_pkg::angle_type ang_in [3];
   atl_pkg::cordic_type x_ff, x_in, y_ff, y_in;
   atl_pkg::zacc_type z_ff, z_in;
   atl_pkg::iter_type iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;
   atl_pkg::angle_type alpha_ff, beta_ff, gamma_ff;

   logic accept;
   logic [8:0] next_count, limit;
   logic report;
   logic all_zero;
   atl_pkg::sample_type samp_cur;
   logic signed [31:0] sq_prod;
   logic signed [16:0] v_ext;
   logic [16:0] v_abs;
   atl_pkg::root_type sqrt_operand;
   atl_pkg::root_type sqrt_root;
   atl_pkg::sqrt_stat_type sqrt_stat;
   logic start_sqrt;
   logic emit_load;
   atl_pkg::cordic_type xs, ys, x_rot, y_rot;
   atl_pkg::zacc_type tab, z_rot;
   logic [26:0] z_clamp;
   logic [27:0] round_sum;
   logic [11:0] mag_wide;
   logic [9:0] mag;
   atl_pkg::angle_type angle_pos, angle_val;

   atl_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (start_sqrt),
      .operand (sqrt_operand),
      .root    (sqrt_root),
      .stat    (sqrt_stat)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign next_count = {1'b0, count_ff} + 9'd1;
   assign limit = (interval_ff == 8'd0) ? 9'd1 : {1'b0, interval_ff};
   assign report = !(next_count < limit);
   assign all_zero = (req_chan.accel_x == '0) && (req_chan.accel_y == '0) &&
                     (req_chan.accel_z == '0);

   assign samp_cur = samp_ff[axis_ff];
   assign sq_prod = 32'(samp_cur) * 32'(samp_cur);
   assign v_ext = {samp_cur[15], samp_cur};
   assign v_abs = samp_cur[15] ? 17'(-v_ext) : 17'(v_ext);

   always_comb begin
      unique case (axis_ff)
         2'd0: sqrt_operand = {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]};
         2'd1: sqrt_operand = {1'b0, sq_ff[0]} + {1'b0, sq_ff[2]};
         2'd2: sqrt_operand = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
         default: sqrt_operand = '0;
      endcase
   end

   always_comb begin
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      tab = {4'd0, atl_pkg::atan_entry(iter_ff)};
      if (!y_ff[35]) begin
         x_rot = x_ff + ys;
         y_rot = y_ff - xs;
         z_rot = z_ff + tab;
      end else begin
         x_rot = x_ff - ys;
         y_rot = y_ff + xs;
         z_rot = z_ff - tab;
      end
   end

   always_comb begin
      if (z_ff[29]) begin
         z_clamp = '0;
      end else if (z_ff[28:0] > {2'b00, atl_pkg::FULL_ANGLE_Q16}) begin
         z_clamp = atl_pkg::FULL_ANGLE_Q16;
      end else begin
         z_clamp = z_ff[26:0];
      end
      round_sum = {1'b0, z_clamp} + 28'h0008000;
      mag_wide = round_sum[27:16];
      mag = (mag_wide > 12'(atl_pkg::FULL_TENTHS)) ? 10'(atl_pkg::FULL_TENTHS) : mag_wide[9:0];
      angle_pos = {1'b0, mag};
      angle_val = samp_cur[15] ? -angle_pos : angle_pos;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      interval_in = csr_write_en ? csr_write_data : interval_ff;
      axis_in = axis_ff;
      samp_in = samp_ff;
      sq_in = sq_ff;
      ang_in = ang_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      start_sqrt = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               samp_in[0] = req_chan.accel_x;
               samp_in[1] = req_chan.accel_y;
               samp_in[2] = req_chan.accel_z;
               count_in = report ? 8'd0 : next_count[7:0];
               if (report && !all_zero) begin
                  axis_in = 2'd0;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            sq_in[axis_ff] = sq_prod[30:0];
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               state_in = ST_LAUNCH;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_LAUNCH: begin
            start_sqrt = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_stat.done) begin
               x_in = {4'd0, sqrt_root};
               y_in = {3'd0, v_abs, 16'd0};
               z_in = '0;
               iter_in = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            x_in = x_rot;
            y_in = y_rot;
            z_in = z_rot;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ang_in[axis_ff] = angle_val;
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               state_in = ST_EMIT;
            end else begin
               axis_in = axis_ff + 2'd1;
               state_in = ST_LAUNCH;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               emit_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         interval_ff <= atl_pkg::REPORT_RESET;
         axis_ff <= '0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         interval_ff <= interval_in;
         axis_ff <= axis_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff <= samp_in;
      sq_ff <= sq_in;
      ang_ff <= ang_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (emit_load) begin
         alpha_ff <= ang_ff[0];
         beta_ff <= ang_ff[1];
         gamma_ff <= ang_ff[2];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.alpha_tenths = alpha_ff;
   assign rsp_chan.beta_tenths = beta_ff;
   assign rsp_chan.gamma_tenths = gamma_ff;

   a_done_in_root: assert property (@(posedge clock) disable iff (reset)
      sqrt_stat.done |-> state_ff == ST_ROOT)
      else $error("Square root finished outside of the root wait state.");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      sqrt_stat.busy |-> !req_chan.ready)
      else $error("Input is ready while the square root unit is busy.");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT |-> iter_ff <= LAST_ITER)
      else $error("Rotation index ran past the last step.");

   a_square_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE && $past(state_ff) == ST_IDLE) |->
         $past(req_chan.valid && req_chan.ready))
      else $error("Angle computation started without an accepted item.");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (alpha_ff >= -11'sd900 && alpha_ff <= 11'sd900 &&
                        beta_ff >= -11'sd900 && beta_ff <= 11'sd900 &&
                        gamma_ff >= -11'sd900 && gamma_ff <= 11'sd900))
      else $error("Result angle outside of plus or minus ninety degrees.");

endmodule
